### hw/rtl/bounded_deque_with_search_unit_assert.svh
// Assertion macros for the deque with search unit.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_UNIT_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define BDQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bdq assertion failed");

// Next-cycle implication, disabled while in reset.
`define BDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bdq assertion failed");

`endif

### hw/rtl/bdq_pkg.sv
// Shared types and defaults for the deque with search unit.
package bdq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OPCODE_W = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SRCH = 3'b010,
    ST_RESP = 3'b100
  } state_t;

endpackage

### hw/rtl/bdq_store.sv
// Ring entry store: one write port, one registered read port.
module bdq_store import bdq_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int IW        = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [IW-1:0]         wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [IW-1:0]         rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/bounded_deque_with_search_unit.sv
// Bounded deque in a ring store with a sequential membership search.
// Push, pop, no-op and empty search: result in the cycle after the request; one per cycle.
// Search over N > 0 entries: one store read and one compare per cycle, stopping at the first hit
// or after the last entry, then a report state; busy while searching.
// Synchronous active-low reset empties the queue; store contents stay undefined.
// Results are strobed for one cycle; the receiver cannot stall.
module bounded_deque_with_search_unit import bdq_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [OPCODE_W-1:0]   in_opcode,
  input  logic [DATA_WIDTH-1:0] in_item_value,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic                  out_found,
  output logic [COUNT_W-1:0]    out_entry_count
);

`include "bounded_deque_with_search_unit_assert.svh"

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DEPTH_W = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  // (a + b) mod DEPTH, with a + b below twice DEPTH
  function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {{(CW + 1 - IW){1'b0}}, a} + {1'b0, b};
    if (s >= DEPTH_W) s = s - DEPTH_W;
    return s[IW-1:0];
  endfunction

  state_t                state_r, state_nxt;
  logic [IW-1:0]         front_r, front_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         issued_r, issued_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  status_t               status_r, status_nxt;
  logic                  found_r, found_nxt;

  logic                  accept;
  logic                  issue;
  logic                  match;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [CW+COUNT_W-1:0] count_ext;

  bdq_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_item_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy   = (state_r == ST_SRCH);
  assign accept = start && !busy;
  assign issue  = (issued_r < count_r);
  assign match  = rd_vld_r && (rd_data == val_r);

  always_comb begin
    state_nxt  = state_r;
    front_nxt  = front_r;
    count_nxt  = count_r;
    issued_nxt = issued_r;
    rd_vld_nxt = 1'b0;
    val_nxt    = val_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    wr_en      = 1'b0;
    wr_addr    = ring_add(front_r, count_r);
    rd_en      = 1'b0;
    rd_addr    = ring_add(front_r, issued_r);

    case (state_r)
      ST_SRCH: begin
        // read entry k while comparing entry k-1
        rd_en      = issue;
        rd_vld_nxt = issue;
        if (issue) issued_nxt = issued_r + 1'b1;
        if (match) begin
          found_nxt  = 1'b1;
          rd_vld_nxt = 1'b0;
          state_nxt  = ST_RESP;
        end else if (!issue && rd_vld_r) begin
          found_nxt = 1'b0;
          state_nxt = ST_RESP;
        end
      end
      ST_IDLE, ST_RESP: begin
        if (accept) begin
          state_nxt  = ST_RESP;
          status_nxt = STAT_DONE;
          found_nxt  = 1'b0;
          case (opcode_t'(in_opcode))
            OP_PUSH_FRONT: begin
              if (count_r >= FULL_CNT) begin
                status_nxt = STAT_FULL;
              end else begin
                front_nxt = (front_r == '0) ? LAST_IDX : front_r - 1'b1;
                wr_en     = 1'b1;
                wr_addr   = front_nxt;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (count_r >= FULL_CNT) begin
                status_nxt = STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                front_nxt = ring_add(front_r, CW'(1));
                count_nxt = count_r - 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (count_r == '0) status_nxt = STAT_EMPTY;
              else count_nxt = count_r - 1'b1;
            end
            OP_SEARCH: begin
              if (count_r != '0) begin
                state_nxt  = ST_SRCH;
                val_nxt    = in_item_value;
                issued_nxt = '0;
              end
            end
            default: ;
          endcase
        end else if (state_r == ST_RESP) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      front_r  <= '0;
      count_r  <= '0;
      issued_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      front_r  <= front_nxt;
      count_r  <= count_nxt;
      issued_r <= issued_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r    <= val_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
  end

  assign count_ext       = {{COUNT_W{1'b0}}, count_r};
  assign out_valid       = (state_r == ST_RESP);
  assign out_status      = status_r;
  assign out_found       = found_r;
  assign out_entry_count = count_ext[COUNT_W-1:0];

  `BDQ_ASSERT_NOW(a_found_only_done, clk, rst_n, out_valid && out_found,
                  out_status == STAT_DONE)
  `BDQ_ASSERT_NOW(a_issue_bounded, clk, rst_n, state_r == ST_SRCH, issued_r <= count_r)
  `BDQ_ASSERT_NEXT(a_request_answered, clk, rst_n, accept, out_valid || busy)
  `BDQ_ASSERT_NEXT(a_full_push_dropped, clk, rst_n,
                   accept && (count_r == FULL_CNT) &&
                   ((in_opcode == OP_PUSH_FRONT) || (in_opcode == OP_PUSH_BACK)),
                   out_valid && (out_status == STAT_FULL) && $stable(count_r))

endmodule

### sim/tb_bounded_deque_with_search_unit.sv
// Testbench for the bounded deque with search unit: random push/pop/search traffic vs. a predictor.
module tb_bounded_deque_with_search_unit import bdq_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEPTH_DEF;
  localparam int DW    = DATA_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 1360;

  // opcodes the block treats as no-ops
  localparam logic [OPCODE_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_RSVD_7 = 3'd7;

  typedef struct {
    status_t             status;
    logic                found;
    logic [COUNT_W-1:0]  count;
  } deque_result_t;

  class deque_scoreboard;
    logic [DW-1:0]  ring [DEPTH];
    int             front;
    int             held;
    deque_result_t  expected_q [$];
    int n_push, n_pop, n_search, n_hits, n_full, n_empty, n_noop;
    int n_results, n_errors;

    function new();
      foreach (ring[k]) ring[k] = '0;
      front = 0;
      held  = 0;
    endfunction

    // advance the deque copy by one accepted request, queue what the block must answer
    function void note_request(logic [OPCODE_W-1:0] op, logic [DW-1:0] val);
      deque_result_t r;
      r.status = STAT_DONE;
      r.found  = 1'b0;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          n_push++;
          if (held >= DEPTH) begin
            r.status = STAT_FULL;
            n_full++;
          end else if (op == OP_PUSH_FRONT) begin
            front = (front + DEPTH - 1) % DEPTH;
            ring[front] = val;
            held++;
          end else begin
            ring[(front + held) % DEPTH] = val;
            held++;
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          n_pop++;
          if (held == 0) begin
            r.status = STAT_EMPTY;
            n_empty++;
          end else begin
            if (op == OP_POP_FRONT) front = (front + 1) % DEPTH;
            held--;
          end
        end
        OP_SEARCH: begin
          n_search++;
          for (int k = 0; k < held; k++) begin
            if (ring[(front + k) % DEPTH] == val) r.found = 1'b1;
          end
          if (r.found) n_hits++;
        end
        default: n_noop++;
      endcase
      r.count = COUNT_W'(held);
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic found,
                               logic [COUNT_W-1:0] count);
      deque_result_t r;
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result status %0d found %0d count %0d",
                 $time, status, found, count);
        n_errors++;
        return;
      end
      r = expected_q.pop_front();
      if (status !== r.status) begin
        $display("%0t: status mismatch exp %0d act %0d", $time, r.status, status);
        n_errors++;
      end
      if (found !== r.found) begin
        $display("%0t: found mismatch exp %0d act %0d", $time, r.found, found);
        n_errors++;
      end
      if (count !== r.count) begin
        $display("%0t: entry_count mismatch exp %0d act %0d", $time, r.count, count);
        n_errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void close_out();
      if (expected_q.size() != 0) begin
        $display("%0t: %0d results never arrived, exp count %0d act none",
                 $time, expected_q.size(), expected_q[0].count);
        n_errors += expected_q.size();
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [OPCODE_W-1:0]   in_opcode;
  logic [DW-1:0]         in_item_value;
  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic                  out_found;
  logic [COUNT_W-1:0]    out_entry_count;

  deque_scoreboard sb;
  logic [DW-1:0]   value_pool [8];

  bounded_deque_with_search_unit #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DW)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_entry_count (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("== FAIL ==");
    $finish;
  end

  // result first: a result and the next request can share an edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_status, out_found, out_entry_count);
      if (start && !busy) sb.note_request(in_opcode, in_item_value);
    end
  end

  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [DW-1:0] val);
    start         <= 1'b1;
    in_opcode     <= op;
    in_item_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    if (n == 0) return;
    start         <= 1'b0;
    in_opcode     <= OPCODE_W'($urandom);
    in_item_value <= DW'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // pool values half the time so searches hit, full-range otherwise
  function automatic logic [DW-1:0] pick_value();
    if ($urandom_range(0, 1) == 0) return value_pool[$urandom_range(0, 7)];
    return DW'($urandom);
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_op(input int mode);
    int w, p_push, p_pop;
    case (mode)
      0:       begin p_push = 65; p_pop = 15; end
      1:       begin p_push = 15; p_pop = 65; end
      2:       begin p_push = 32; p_pop = 32; end
      default: begin p_push = 20; p_pop = 20; end
    endcase
    w = $urandom_range(0, 99);
    if (w < 4) return OPCODE_W'($urandom_range(OP_RSVD_5, OP_RSVD_7));
    if (w < 4 + p_push) return ($urandom_range(0, 1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (w < 4 + p_push + p_pop)
      return ($urandom_range(0, 1) != 0) ? OP_POP_BACK : OP_POP_FRONT;
    return OP_SEARCH;
  endfunction

  initial begin
    int real_items;
    int seg_len;
    int mode;
    bit no_idle;
    logic [OPCODE_W-1:0] op;

    sb = new();
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_opcode     <= OP_PUSH_FRONT;
    in_item_value <= '0;
    value_pool[0] = '0;
    value_pool[1] = '1;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7fff_ffff;
    value_pool[4] = 32'h5555_5555;
    value_pool[5] = 32'haaaa_aaaa;
    value_pool[6] = DW'($urandom);
    value_pool[7] = DW'($urandom);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue, then the unused opcodes
    send_request(OP_POP_FRONT, '1);
    send_request(OP_POP_BACK, '0);
    send_request(OP_SEARCH, '0);
    send_request(OP_RSVD_5, '1);
    send_request(OP_RSVD_6, '0);
    send_request(OP_RSVD_7, 32'h1234_5678);
    // fill to the bound from both ends, then overflow both ends
    send_request(OP_PUSH_BACK, '1);
    send_request(OP_PUSH_FRONT, '0);
    for (int k = 0; k < DEPTH - 2; k++) begin
      send_request((k % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                   (k < 6) ? value_pool[k + 2] : DW'($urandom));
    end
    send_request(OP_PUSH_FRONT, 32'hdead_beef);
    send_request(OP_PUSH_BACK, 32'hdead_beef);
    send_request(OP_SEARCH, '1);
    send_request(OP_SEARCH, 32'hdead_beef);
    send_request(OP_POP_FRONT, '0);
    send_request(OP_POP_BACK, '0);
    wait_drained();

    real_items = 0;
    while (real_items < RANDOM_ITEMS) begin
      seg_len = $urandom_range(8, 40);
      mode    = $urandom_range(0, 3);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < seg_len; i++) begin
        op = pick_op(mode);
        send_request(op, pick_value());
        if (op <= OP_SEARCH) real_items++;
        if (!no_idle) idle_cycles(pick_gap());
      end
      if ($urandom_range(0, 5) == 0) wait_drained();
    end

    wait_drained();
    repeat (DEPTH + 8) @(posedge clk);
    sb.close_out();

    $display("covered %0d pushes (%0d dropped full), %0d pops (%0d on empty), %0d no-ops",
             sb.n_push, sb.n_full, sb.n_pop, sb.n_empty, sb.n_noop);
    $display("covered %0d searches (%0d hits); %0d results checked, %0d errors",
             sb.n_search, sb.n_hits, sb.n_results, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
